/* design/dps_pkg.sv */
// ============================================================================
// dps_pkg: shared types and constants of the double pulse sequencer
// Phase codes, register indexes, reset values and the result item layout.
// ============================================================================
package dps_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int NUM_REGS    = 5;
    localparam int ITEM_DATA_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_HALF   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLANKING     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_PULSE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP          = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_PULSE = 3'd4;

    localparam logic [CFG_DATA_W-1:0] RST_BLINK_HALF   = 32'd100000000;
    localparam logic [CFG_DATA_W-1:0] RST_BLANKING     = 32'd10000;
    localparam logic [CFG_DATA_W-1:0] RST_FIRST_PULSE  = 32'd500;
    localparam logic [CFG_DATA_W-1:0] RST_GAP          = 32'd200;
    localparam logic [CFG_DATA_W-1:0] RST_SECOND_PULSE = 32'd100;

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_BLANK  = 3'd1,
        PH_PULSE1 = 3'd2,
        PH_GAP    = 3'd3,
        PH_PULSE2 = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    // First field in the highest bit.
    typedef struct packed {
        logic sequence_done;
        logic armed_led_on;
        logic status_led_on;
        logic pulse_out;
    } dps_result_t;

endpackage

/* design/dps_cfg_regs.sv */
// ============================================================================
// dps_cfg_regs: configuration registers
// Holds the five duration registers and presents them clamped to the width
// of the tick counters.
// ============================================================================
module dps_cfg_regs
    import dps_pkg::*;
#(
    parameter int TICK_COUNT_BITS = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wen,
    input  logic [CFG_INDEX_W-1:0]                  cfg_index,
    input  logic [CFG_DATA_W-1:0]                   cfg_wdata,
    output logic [NUM_REGS-1:0][TICK_COUNT_BITS-1:0] limits
);

    localparam int LW = (TICK_COUNT_BITS > CFG_DATA_W) ? TICK_COUNT_BITS : CFG_DATA_W;

    logic [NUM_REGS-1:0][CFG_DATA_W-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg[REG_BLINK_HALF]   <= RST_BLINK_HALF;
            value_reg[REG_BLANKING]     <= RST_BLANKING;
            value_reg[REG_FIRST_PULSE]  <= RST_FIRST_PULSE;
            value_reg[REG_GAP]          <= RST_GAP;
            value_reg[REG_SECOND_PULSE] <= RST_SECOND_PULSE;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_BLINK_HALF:   value_reg[REG_BLINK_HALF]   <= cfg_wdata;
                REG_BLANKING:     value_reg[REG_BLANKING]     <= cfg_wdata;
                REG_FIRST_PULSE:  value_reg[REG_FIRST_PULSE]  <= cfg_wdata;
                REG_GAP:          value_reg[REG_GAP]          <= cfg_wdata;
                REG_SECOND_PULSE: value_reg[REG_SECOND_PULSE] <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    localparam logic [LW-1:0] CNT_MAX_EXT = LW'({TICK_COUNT_BITS{1'b1}});

    always_comb
    begin
        logic [LW-1:0] v_ext;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            v_ext = LW'(value_reg[i]);
            if (v_ext > CNT_MAX_EXT)
                limits[i] = CNT_MAX_EXT[TICK_COUNT_BITS-1:0];
            else
                limits[i] = v_ext[TICK_COUNT_BITS-1:0];
        end
    end

endmodule

/* design/dps_core.sv */
// ============================================================================
// dps_core: phase sequencer
// Advances the waiting blink counter or the timed phase counter by one tick
// for each item and forms the result item for that tick.
// ============================================================================
module dps_core
    import dps_pkg::*;
#(
    parameter int TICK_COUNT_BITS = 32
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     step_en,
    input  logic                                     button_level,
    input  logic [NUM_REGS-1:0][TICK_COUNT_BITS-1:0] limits,
    output dps_result_t                              result
);

    localparam logic [TICK_COUNT_BITS-1:0] CNT_MAX = {TICK_COUNT_BITS{1'b1}};

    phase_t                     phase_reg, phase_next;
    logic [TICK_COUNT_BITS-1:0] phase_count_reg, phase_count_next;
    logic [TICK_COUNT_BITS-1:0] blink_count_reg, blink_count_next;
    logic                       status_led_reg, status_led_next;

    logic [TICK_COUNT_BITS-1:0] blink_inc;
    logic [TICK_COUNT_BITS-1:0] phase_inc;
    logic [TICK_COUNT_BITS-1:0] phase_limit;

    assign blink_inc = blink_count_reg + TICK_COUNT_BITS'(1);
    assign phase_inc = (phase_count_reg == CNT_MAX) ? phase_count_reg
                                                    : phase_count_reg + TICK_COUNT_BITS'(1);

    always_comb
    begin
        unique case (phase_reg)
            PH_BLANK:  phase_limit = limits[REG_BLANKING];
            PH_PULSE1: phase_limit = limits[REG_FIRST_PULSE];
            PH_GAP:    phase_limit = limits[REG_GAP];
            default:   phase_limit = limits[REG_SECOND_PULSE];
        endcase
    end

    // Next state.
    always_comb
    begin
        phase_next       = phase_reg;
        phase_count_next = phase_count_reg;
        blink_count_next = blink_count_reg;
        status_led_next  = status_led_reg;
        unique case (phase_reg)
            PH_WAIT:
            begin
                if (!button_level)
                begin
                    status_led_next  = 1'b0;
                    phase_next       = PH_BLANK;
                    phase_count_next = '0;
                end
                else if (blink_inc >= limits[REG_BLINK_HALF])
                begin
                    status_led_next  = ~status_led_reg;
                    blink_count_next = '0;
                end
                else
                begin
                    blink_count_next = blink_inc;
                end
            end
            PH_BLANK, PH_PULSE1, PH_GAP, PH_PULSE2:
            begin
                if (phase_inc >= phase_limit)
                begin
                    phase_count_next = '0;
                    unique case (phase_reg)
                        PH_BLANK:  phase_next = PH_PULSE1;
                        PH_PULSE1: phase_next = PH_GAP;
                        PH_GAP:    phase_next = PH_PULSE2;
                        default:   phase_next = PH_DONE;
                    endcase
                end
                else
                begin
                    phase_count_next = phase_inc;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // Outputs for this tick.
    always_comb
    begin
        result               = '0;
        result.status_led_on = status_led_next;
        unique case (phase_reg)
            PH_WAIT:
            begin
                result.armed_led_on = ~button_level;
            end
            PH_BLANK, PH_GAP:
            begin
                result.armed_led_on = 1'b1;
            end
            PH_PULSE1, PH_PULSE2:
            begin
                result.armed_led_on = 1'b1;
                result.pulse_out    = 1'b1;
            end
            default:
            begin
                result.armed_led_on  = 1'b1;
                result.sequence_done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT;
            phase_count_reg <= '0;
            blink_count_reg <= '0;
            status_led_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            phase_count_reg <= phase_count_next;
            blink_count_reg <= blink_count_next;
            status_led_reg  <= status_led_next;
        end
    end

endmodule

/* design/double_pulse_sequencer.sv */
// ============================================================================
// double_pulse_sequencer: double pulse test generator
// Stream wrapper around the phase sequencer with input and result registers.
// ============================================================================
// Each input item is one base-clock tick carrying the trigger button level
// (active low). The block takes one item per clock cycle unless a stalled
// output holds it back, and returns one result item per input item: the item
// is held in the input register, then the phase and counter update in the
// core writes the result register. Durations, set on the configuration port,
// are clamped to the TICK_COUNT_BITS-wide tick counters; a value of zero acts
// as one tick. After the second pulse the block stays done until reset.
module double_pulse_sequencer
    import dps_pkg::*;
#(
    parameter int TICK_COUNT_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [ITEM_DATA_W-1:0] s_tdata,   // [0] button_level
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [ITEM_DATA_W-1:0] m_tdata    // [0] pulse_out, [1] status_led_on,
                                              // [2] armed_led_on, [3] sequence_done
);

    logic        in_valid_reg;
    logic        in_button_reg;
    logic        out_valid_reg;
    dps_result_t out_data_reg;
    dps_result_t result;
    logic        advance;

    logic [NUM_REGS-1:0][TICK_COUNT_BITS-1:0] limits;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(ITEM_DATA_W - $bits(dps_result_t))'(0), out_data_reg};

    dps_cfg_regs #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .limits    (limits)
    );

    dps_core #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .button_level (in_button_reg),
        .limits       (limits),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_button_reg <= s_tdata[0];
        if (advance)
            out_data_reg <= result;
    end

endmodule
